// ===== sv/ptd_pkg.sv =====
// Package for the periodic task dispatcher: slot count, command codes,
// word types and the sequencer state type. No dependencies.
`default_nettype none
package ptd_pkg;

    localparam int TASK_SLOTS = 8;
    localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W      = 16;

    typedef enum logic [2:0] {
        CMD_CREATE  = 3'd0,
        CMD_SUSPEND = 3'd1,
        CMD_RESUME  = 3'd2,
        CMD_DELETE  = 3'd3,
        CMD_TICK    = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  task_id;
        logic [15:0] period;
    } t_in_word;

    typedef struct packed {
        logic       status;
        logic       dispatch_valid;
        logic [2:0] dispatch_task;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic             match;
        logic [CNT_W-1:0] next_count;
    } t_step_res;

endpackage
`default_nettype wire

// ===== sv/ptd_step_unit.sv =====
// Shared compare and increment unit used once per slot during a tick scan.
// Depends on ptd_pkg.
`default_nettype none
module ptd_step_unit (
    input  wire logic [ptd_pkg::CNT_W-1:0] i_count,
    input  wire logic [ptd_pkg::CNT_W-1:0] i_period,
    output ptd_pkg::t_step_res             o_res
);
    import ptd_pkg::*;

    always_comb begin
        o_res.match = (i_count == i_period);
        if (o_res.match) begin
            o_res.next_count = CNT_W'(1);
        end else begin
            o_res.next_count = i_count + CNT_W'(1);
        end
    end

endmodule
`default_nettype wire

// ===== sv/periodic_task_dispatcher.sv =====
// Top level of the periodic task dispatcher: slot table, scan sequencer and
// output register. Depends on ptd_pkg and ptd_step_unit.
//
//   channel  | valid    | stall    | word
//   ---------+----------+----------+-------------
//   command  | i_valid  | o_stall  | i_cmd_word
//   result   | o_valid  | i_stall  | o_res_word
//
// A tick scans one slot per cycle through the shared step unit while no stalled
// result word holds the scan, then issues the final word from the flush state
// before the next command word is accepted.
// Reset clears the occupied, ready and counter stores and the sequencer.
// A stalled result word holds the scan at the next dispatch that needs it.
`default_nettype none
module periodic_task_dispatcher (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire ptd_pkg::t_in_word  i_cmd_word,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output ptd_pkg::t_out_word      o_res_word
);
    import ptd_pkg::*;

    t_state                  r_state, n_state;
    logic [TASK_SLOTS-1:0]   r_used, n_used;
    logic [TASK_SLOTS-1:0]   r_ready, n_ready;
    logic [CNT_W-1:0]        r_period [TASK_SLOTS];
    logic [CNT_W-1:0]        r_count [TASK_SLOTS];
    logic [CNT_W-1:0]        n_count;
    logic                    count_we;
    logic                    period_we;
    logic [SLOT_W-1:0]       r_idx, n_idx;
    logic [SLOT_W-1:0]       r_pend, n_pend;
    logic                    r_have, n_have;
    logic                    r_out_valid, n_out_valid;
    t_out_word               r_out, n_out;
    logic                    out_free;
    logic                    in_acc;
    logic                    in_range;
    logic [SLOT_W-1:0]       cmd_slot;
    logic                    due;
    logic                    scan_go;
    logic                    scan_end;
    t_step_res               step;

    ptd_step_unit u_step (
        .i_count  (r_count[r_idx]),
        .i_period (r_period[r_idx]),
        .o_res    (step)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = !((r_state == S_IDLE) && out_free);
    assign in_acc   = i_valid && !o_stall;
    assign in_range = int'(i_cmd_word.task_id) < TASK_SLOTS;
    assign cmd_slot = SLOT_W'(i_cmd_word.task_id);
    assign due      = r_used[r_idx] && r_ready[r_idx] && step.match;
    assign scan_go  = !(due && r_have) || out_free;
    assign scan_end = (r_idx == SLOT_W'(TASK_SLOTS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_cmd_word.cmd == CMD_TICK)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_go && scan_end) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_used      = r_used;
        n_ready     = r_ready;
        n_count     = step.next_count;
        count_we    = 1'b0;
        period_we   = 1'b0;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_have      = r_have;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_idx  = '0;
                    n_have = 1'b0;
                    if (i_cmd_word.cmd != CMD_TICK) begin
                        n_out_valid = 1'b1;
                        n_out       = '{status: 1'b0, dispatch_valid: 1'b0,
                                        dispatch_task: 3'd0, last: 1'b1};
                        case (i_cmd_word.cmd)
                            CMD_CREATE: begin
                                if (!in_range || r_used[cmd_slot]) begin
                                    n_out.status = 1'b1;
                                end else begin
                                    period_we         = 1'b1;
                                    n_used[cmd_slot]  = 1'b1;
                                    n_ready[cmd_slot] = 1'b1;
                                end
                            end
                            CMD_SUSPEND: begin
                                if (in_range) n_ready[cmd_slot] = 1'b0;
                            end
                            CMD_RESUME: begin
                                if (in_range) n_ready[cmd_slot] = 1'b1;
                            end
                            CMD_DELETE: begin
                                if (in_range) n_used[cmd_slot] = 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_SCAN: begin
                if (scan_go) begin
                    count_we = r_used[r_idx] && r_ready[r_idx];
                    n_idx    = r_idx + SLOT_W'(1);
                    if (due) begin
                        if (r_have) begin
                            n_out_valid = 1'b1;
                            n_out       = '{status: 1'b0, dispatch_valid: 1'b1,
                                            dispatch_task: 3'(r_pend), last: 1'b0};
                        end
                        n_pend = r_idx;
                        n_have = 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{status: 1'b0, dispatch_valid: r_have,
                                    dispatch_task: r_have ? 3'(r_pend) : 3'd0,
                                    last: 1'b1};
                    n_have      = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_ready     <= '0;
            r_idx       <= '0;
            r_pend      <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < TASK_SLOTS; i++) begin
                r_count[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_ready     <= n_ready;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
            if (count_we) begin
                r_count[r_idx] <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (period_we) begin
            r_period[cmd_slot] <= i_cmd_word.period;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_res_word = r_out;

    a_tick_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_cmd_word.cmd == CMD_TICK)) |=> (r_state == S_SCAN))
        else $error("tick did not start a scan");

    a_non_last_is_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last) |-> r_out.dispatch_valid)
        else $error("non-final word without a dispatch");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_have)
        else $error("pending dispatch left after a tick");

    a_scan_leaves_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FLUSH) && out_free) |=> (r_out_valid && r_out.last))
        else $error("final word of a tick missing");

endmodule
`default_nettype wire

// ===== tb/periodic_task_dispatcher_tb.sv =====
// Self-checking testbench for periodic_task_dispatcher: a scoreboard class keeps its own
// copy of the slot table, predicts the result words of every accepted command word and
// checks them in order. Depends on ptd_pkg and the dispatcher RTL only.
module periodic_task_dispatcher_tb;

    import ptd_pkg::*;

    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam int         RANDOM_WORDS    = 420;

    class dispatch_scoreboard;
        bit        used [TASK_SLOTS];
        bit        ready [TASK_SLOTS];
        bit [15:0] period [TASK_SLOTS];
        bit [15:0] count [TASK_SLOTS];
        t_out_word due_words [$];
        int        errors;

        task report(input string msg);
            $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        function void apply_command(input t_in_word w);
            t_out_word res;
            int        hits;
            bit        inrange;
            inrange = w.task_id < TASK_SLOTS;
            res     = '0;
            hits    = 0;
            if (w.cmd == CMD_TICK) begin
                for (int i = 0; i < TASK_SLOTS; i++) begin
                    if (used[i] && ready[i]) begin
                        if (count[i] == period[i]) begin
                            count[i] = 16'd1;
                            res = '0;
                            res.dispatch_valid = 1'b1;
                            res.dispatch_task  = 3'(i);
                            due_words.push_back(res);
                            hits++;
                        end else begin
                            count[i] = count[i] + 16'd1;
                        end
                    end
                end
                if (hits == 0) begin
                    res = '0;
                    res.last = 1'b1;
                    due_words.push_back(res);
                end else begin
                    due_words[due_words.size() - 1].last = 1'b1;
                end
            end else begin
                case (w.cmd)
                    CMD_CREATE: begin
                        if (!inrange || used[w.task_id]) begin
                            res.status = 1'b1;
                        end else begin
                            period[w.task_id] = w.period;
                            used[w.task_id]   = 1'b1;
                            ready[w.task_id]  = 1'b1;
                        end
                    end
                    CMD_SUSPEND: begin
                        if (inrange) ready[w.task_id] = 1'b0;
                    end
                    CMD_RESUME: begin
                        if (inrange) ready[w.task_id] = 1'b1;
                    end
                    CMD_DELETE: begin
                        if (inrange) used[w.task_id] = 1'b0;
                    end
                    default: begin
                    end
                endcase
                res.last = 1'b1;
                due_words.push_back(res);
            end
        endfunction

        task check_word(input t_out_word got);
            t_out_word want;
            if (due_words.size() == 0) begin
                report($sformatf("unexpected result word %h", got));
            end else begin
                want = due_words.pop_front();
                if (got.status !== want.status)
                    report($sformatf("status %b, expected %b", got.status, want.status));
                if (got.dispatch_valid !== want.dispatch_valid)
                    report($sformatf("dispatch_valid %b, expected %b",
                                     got.dispatch_valid, want.dispatch_valid));
                if (got.dispatch_task !== want.dispatch_task)
                    report($sformatf("dispatch_task %0d, expected %0d",
                                     got.dispatch_task, want.dispatch_task));
                if (got.last !== want.last)
                    report($sformatf("last %b, expected %b", got.last, want.last));
            end
        endtask
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_word  i_cmd_word = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_word o_res_word;

    dispatch_scoreboard sb;
    bit                 tx_quiet;
    bit                 rx_quiet;
    int                 stall_left;

    periodic_task_dispatcher u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_cmd_word (i_cmd_word),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_res_word (o_res_word)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                sb.check_word(o_res_word);
                stall_left = rx_quiet ? 0 : $urandom_range(9, 0);
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
            end
            i_stall <= (stall_left > 0);
        end
    end

    task automatic issue(input logic [2:0] cmd, input int id, input logic [15:0] per);
        t_in_word w;
        int       gap;
        w.cmd     = cmd;
        w.task_id = 3'(id);
        w.period  = per;
        gap = tx_quiet ? 0 : $urandom_range(9, 0);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd_word <= w;
        do @(posedge i_clk); while (o_stall);
        sb.apply_command(w);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.due_words.size() > 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_period(input int id);
        int r;
        r = $urandom_range(99, 0);
        if (r < 55)
            return sb.count[id] + 16'($urandom_range(4, 0));
        else if (r < 80)
            return 16'($urandom_range(6, 0));
        return 16'($urandom());
    endfunction

    initial begin
        int r;
        int id;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty tick, immediate dispatch with period zero, taken slot,
        // period extremes, suspend/resume/delete on used and free slots, spare codes.
        issue(CMD_TICK, 0, 16'd0);
        issue(CMD_CREATE, 0, 16'd0);
        issue(CMD_CREATE, 0, 16'd5);
        issue(CMD_CREATE, 7, 16'hFFFF);
        issue(CMD_CREATE, 3, 16'd1);
        issue(CMD_TICK, 0, 16'd0);
        issue(CMD_TICK, 0, 16'd0);
        issue(CMD_SUSPEND, 3, 16'd0);
        issue(CMD_TICK, 0, 16'd0);
        issue(CMD_RESUME, 3, 16'd0);
        issue(CMD_DELETE, 7, 16'd0);
        issue(CMD_DELETE, 7, 16'd0);
        issue(CMD_SUSPEND, 5, 16'd0);
        issue(CMD_RESUME, 5, 16'd0);
        issue(CMD_SPARE_FIRST, 2, 16'hAAAA);
        issue(CMD_SPARE_LAST, 6, 16'h5555);
        issue(CMD_CREATE, 7, 16'h5555);
        for (int i = 1; i < 7; i++) begin
            if (i != 3) issue(CMD_CREATE, i, 16'd1);
        end
        issue(CMD_TICK, 0, 16'd0);
        issue(CMD_TICK, 0, 16'd0);
        wait_drained();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 40 == 0) begin
                tx_quiet = ($urandom_range(2, 0) == 0);
                rx_quiet = ($urandom_range(2, 0) == 0);
            end
            if (n == RANDOM_WORDS / 2) wait_drained();
            r  = $urandom_range(99, 0);
            id = $urandom_range(7, 0);
            if (r < 45)
                issue(CMD_TICK, id, 16'($urandom()));
            else if (r < 65)
                issue(CMD_CREATE, id, pick_period(id));
            else if (r < 73)
                issue(CMD_SUSPEND, id, 16'($urandom()));
            else if (r < 83)
                issue(CMD_RESUME, id, 16'($urandom()));
            else if (r < 93)
                issue(CMD_DELETE, id, 16'($urandom()));
            else
                issue(3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)), id,
                      16'($urandom()));
        end

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ptd_pkg.sv
sv/ptd_step_unit.sv
sv/periodic_task_dispatcher.sv
tb/periodic_task_dispatcher_tb.sv
